### hw/rtl/wpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_pkg: shared types and constants of the windowed peak/rms meter
// Holds the register map, the fixed field widths, the sequencer state type
// and the band compare used at window close.
// ----------------------------------------------------------------------------
package wpm_pkg;

  // fixed field widths
  localparam int WIN_BITS   = 16;
  localparam int GAIN_BITS  = 24;
  localparam int LOW_BITS   = 21;
  localparam int VALUE_BITS = 20;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int Q_SHIFT    = 16;

  // 1/sqrt(2) in Q16 and the saturation limit of peak and rms
  localparam logic [15:0]           INV_SQRT2_Q16 = 16'd46341;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX     = 20'd1048575;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_GAIN          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_ONE_LOW       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_ONE_HIGH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_TWO_LOW       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_TWO_HIGH      = 3'd5;

  // register reset values
  localparam logic [WIN_BITS-1:0]          RST_SAMPLES_PER_WINDOW = 16'd1000;
  localparam logic [GAIN_BITS-1:0]         RST_PEAK_GAIN          = 24'd211253;
  localparam logic signed [LOW_BITS-1:0]   RST_BAND_ONE_LOW       = 21'sd9000;
  localparam logic [VALUE_BITS-1:0]        RST_BAND_ONE_HIGH      = 20'd13000;
  localparam logic signed [LOW_BITS-1:0]   RST_BAND_TWO_LOW       = 21'sd19800;
  localparam logic [VALUE_BITS-1:0]        RST_BAND_TWO_HIGH      = 20'd24200;

  // window-close sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_PEAK,
    ST_MUL_RMS,
    ST_BAND,
    ST_HOLD
  } wpm_state_t;

  // control from sequencer to datapath
  typedef struct packed {
    logic busy;
    logic mul_rms;
    logic cap_peak;
    logic load_out;
    logic out_valid;
  } wpm_ctrl_t;

  // strict band membership: lo < x < hi, lo signed
  function automatic logic in_band(input logic [VALUE_BITS-1:0] x,
                                   input logic signed [LOW_BITS-1:0] lo,
                                   input logic [VALUE_BITS-1:0] hi);
    logic signed [LOW_BITS:0] xs;
    logic signed [LOW_BITS:0] los;
    begin
      xs  = $signed({2'b00, x});
      los = $signed({lo[LOW_BITS-1], lo});
      return (xs > los) && (x < hi);
    end
  endfunction

endpackage

### hw/rtl/wpm_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_mul: shared multiplier
// Unsigned multiply with a registered product; used once for the peak
// scaling and once for the rms scaling of each window.
// ----------------------------------------------------------------------------
module wpm_mul #(
  parameter int A_W = 20,
  parameter int B_W = 24
) (
  input  logic               clk,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  // product register
  always_ff @(posedge clk) begin
    p <= A_W'(a) * B_W'(b);
  end

endmodule

### hw/rtl/wpm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_ctrl: window-close sequencer
// Steps the shared multiplier through peak and rms scaling, then the band
// compare, then holds the result item until it is taken.
// ----------------------------------------------------------------------------
module wpm_ctrl import wpm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      out_take,
  output wpm_ctrl_t ctrl
);

  wpm_state_t state;
  wpm_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (start) state_next = ST_MUL_PEAK;
      ST_MUL_PEAK: state_next = ST_MUL_RMS;
      ST_MUL_RMS:  state_next = ST_BAND;
      ST_BAND:     state_next = ST_HOLD;
      ST_HOLD:     if (out_take) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // decoded controls
  always_comb begin
    ctrl = '0;
    unique case (state)
      ST_IDLE: begin
        ctrl.busy = 1'b0;
      end
      ST_MUL_PEAK: begin
        ctrl.busy = 1'b1;
      end
      ST_MUL_RMS: begin
        ctrl.busy     = 1'b1;
        ctrl.mul_rms  = 1'b1;
        ctrl.cap_peak = 1'b1;
      end
      ST_BAND: begin
        ctrl.busy     = 1'b1;
        ctrl.load_out = 1'b1;
      end
      ST_HOLD: begin
        ctrl.busy      = 1'b1;
        ctrl.out_valid = 1'b1;
      end
      default: begin
        ctrl.busy = 1'b1;
      end
    endcase
  end

endmodule

### hw/rtl/windowed_peak_rms_meter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_peak_rms_meter_unit: windowed peak-to-peak and rms meter
// Tracks min and max code over a window; at window close scales the span to
// peak and rms through one shared multiplier and flags band membership.
// ----------------------------------------------------------------------------
// Window close: a sample that closes a window gives its result item after two
//   passes of the shared multiplier, then the band compare.
// Throughput: one sample per cycle inside a window; a closing sample blocks
//   input through the multiplier and band steps and until its result item is taken.
// Reset: synchronous, active high; registers take their documented defaults,
//   the window is cleared and no result item is pending.
// ----------------------------------------------------------------------------
module windowed_peak_rms_meter_unit import wpm_pkg::*; #(
  parameter int ADC_BITS   = 12,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // sample channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADC_BITS-1:0]   sample_code,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ADC_BITS-1:0]   span_code,
  output logic [VALUE_BITS-1:0] peak_value,
  output logic [VALUE_BITS-1:0] rms_value,
  output logic                  in_range,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PEAK_W = ADC_BITS + GAIN_BITS - Q_SHIFT;
  localparam int PROD_W = PEAK_W + GAIN_BITS;
  localparam int SAT_W  = (PEAK_W > VALUE_BITS) ? PEAK_W : VALUE_BITS;
  localparam int CMP_W  = (COUNT_BITS + 1 > WIN_BITS) ? COUNT_BITS + 1 : WIN_BITS;

  // configuration registers
  logic [WIN_BITS-1:0]          samples_per_window;
  logic [GAIN_BITS-1:0]         peak_gain;
  logic signed [LOW_BITS-1:0]   band_one_low;
  logic [VALUE_BITS-1:0]        band_one_high;
  logic signed [LOW_BITS-1:0]   band_two_low;
  logic [VALUE_BITS-1:0]        band_two_high;

  // window state
  logic [COUNT_BITS-1:0]        sample_count;
  logic [ADC_BITS-1:0]          max_code;
  logic [ADC_BITS-1:0]          min_code;
  logic [ADC_BITS-1:0]          max_next;
  logic [ADC_BITS-1:0]          min_next;
  logic [ADC_BITS-1:0]          span;
  logic [CMP_W-1:0]             win_len;
  logic [CMP_W-1:0]             count_inc;
  logic                         in_take;
  logic                         window_close;

  // datapath
  wpm_ctrl_t                    ctrl;
  logic [PEAK_W-1:0]            mul_a;
  logic [GAIN_BITS-1:0]         mul_b;
  logic [PROD_W-1:0]            prod;
  logic [PEAK_W-1:0]            prod_q;
  logic [VALUE_BITS-1:0]        prod_sat;
  logic [SAT_W-1:0]             prod_ext;
  logic [VALUE_BITS-1:0]        peak_hold;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_window <= RST_SAMPLES_PER_WINDOW;
      peak_gain          <= RST_PEAK_GAIN;
      band_one_low       <= RST_BAND_ONE_LOW;
      band_one_high      <= RST_BAND_ONE_HIGH;
      band_two_low       <= RST_BAND_TWO_LOW;
      band_two_high      <= RST_BAND_TWO_HIGH;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SAMPLES_PER_WINDOW: samples_per_window <= cfg_data[WIN_BITS-1:0];
        CFG_PEAK_GAIN:          peak_gain          <= cfg_data[GAIN_BITS-1:0];
        CFG_BAND_ONE_LOW:       band_one_low       <= $signed(cfg_data[LOW_BITS-1:0]);
        CFG_BAND_ONE_HIGH:      band_one_high      <= cfg_data[VALUE_BITS-1:0];
        CFG_BAND_TWO_LOW:       band_two_low       <= $signed(cfg_data[LOW_BITS-1:0]);
        CFG_BAND_TWO_HIGH:      band_two_high      <= cfg_data[VALUE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // min/max fold and window-end test
  always_comb begin
    in_take   = in_valid && !in_stall;
    max_next  = (sample_code > max_code) ? sample_code : max_code;
    min_next  = (sample_code < min_code) ? sample_code : min_code;
    win_len   = (samples_per_window == '0) ? CMP_W'(1) : CMP_W'(samples_per_window);
    count_inc = CMP_W'(sample_count) + CMP_W'(1);
    window_close = !((count_inc < win_len) && (sample_count != '1));
  end

  // window state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      max_code     <= '0;
      min_code     <= '1;
    end else if (in_take) begin
      if (window_close) begin
        sample_count <= '0;
        max_code     <= '0;
        min_code     <= '1;
      end else begin
        sample_count <= sample_count + COUNT_BITS'(1);
        max_code     <= max_next;
        min_code     <= min_next;
      end
    end
  end

  // span of the closing window
  always_ff @(posedge clk) begin
    if (in_take && window_close) begin
      span <= max_next - min_next;
    end
  end

  wpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (in_take && window_close),
    .out_take (!out_stall),
    .ctrl     (ctrl)
  );

  // shared multiplier operands: span*gain, then peak*1/sqrt2
  always_comb begin
    if (ctrl.mul_rms) begin
      mul_a = prod_q;
      mul_b = GAIN_BITS'(INV_SQRT2_Q16);
    end else begin
      mul_a = PEAK_W'(span);
      mul_b = peak_gain;
    end
  end

  wpm_mul #(
    .A_W (PEAK_W),
    .B_W (GAIN_BITS)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Q16 rescale and saturation of the registered product
  always_comb begin
    prod_q   = prod[Q_SHIFT +: PEAK_W];
    prod_ext = SAT_W'(prod_q);
    prod_sat = (prod_ext > SAT_W'(VALUE_MAX)) ? VALUE_MAX : prod_ext[VALUE_BITS-1:0];
  end

  // peak capture and result registers
  always_ff @(posedge clk) begin
    if (ctrl.cap_peak) begin
      peak_hold <= prod_sat;
    end
    if (ctrl.load_out) begin
      span_code  <= span;
      peak_value <= peak_hold;
      rms_value  <= prod_sat;
      in_range   <= in_band(prod_sat, band_one_low, band_one_high) ||
                    in_band(prod_sat, band_two_low, band_two_high);
    end
  end

  // handshake
  assign in_stall  = ctrl.busy;
  assign out_valid = ctrl.out_valid;

endmodule

### hw/rtl/wpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_checker: port-level checks of the meter
// Watches the top-level ports for result ordering and handshake behavior.
// ----------------------------------------------------------------------------
module wpm_checker import wpm_pkg::*; #(
  parameter int ADC_BITS = 12
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [ADC_BITS-1:0]   span_code,
  input logic [VALUE_BITS-1:0] peak_value,
  input logic [VALUE_BITS-1:0] rms_value,
  input logic                  in_range
);

  // no sample is taken while a result item is pending
  assert property (@(posedge clk) disable iff (rst) !in_stall |-> !out_valid)
    else $error("input open while result item pending");

  // a result item appears only after input was already closed
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(in_stall))
    else $error("result item without a preceding busy phase");

  // rms never exceeds peak
  assert property (@(posedge clk) disable iff (rst) out_valid |-> rms_value <= peak_value)
    else $error("rms above peak");

  // stalled result item holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(span_code) && $stable(peak_value) &&
                               $stable(rms_value) && $stable(in_range))
    else $error("stalled result item changed");

endmodule

bind windowed_peak_rms_meter_unit wpm_checker #(.ADC_BITS(ADC_BITS)) u_wpm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .span_code  (span_code),
  .peak_value (peak_value),
  .rms_value  (rms_value),
  .in_range   (in_range)
);

### bench/wpm_reading_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_reading_checker: result checker for the windowed peak/rms meter
// Watches the sample, result and register ports. Keeps its own copy of the
// registers and the window min/max, works out each window's reading
// (span, peak, rms, band flag) and compares it with the result item that
// the meter hands out. Hands the error count and the number of readings
// still due back to the bench.
// ----------------------------------------------------------------------------
module wpm_reading_checker import wpm_pkg::*; #(
  parameter int ADC_BITS   = 12,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [ADC_BITS-1:0]   sample_code,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [ADC_BITS-1:0]   span_code,
  input  logic [VALUE_BITS-1:0] peak_value,
  input  logic [VALUE_BITS-1:0] rms_value,
  input  logic                  in_range,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_readings
);

  typedef struct {
    logic [ADC_BITS-1:0]   span;
    logic [VALUE_BITS-1:0] peak;
    logic [VALUE_BITS-1:0] rms;
    logic                  hit;
  } reading_t;

  reading_t readings_due[$];
  int       errors = 0;

  // register mirror
  logic [WIN_BITS-1:0]          win_len;
  logic [GAIN_BITS-1:0]         gain;
  logic signed [LOW_BITS-1:0]   b1_lo;
  logic [VALUE_BITS-1:0]        b1_hi;
  logic signed [LOW_BITS-1:0]   b2_lo;
  logic [VALUE_BITS-1:0]        b2_hi;

  // window state
  logic [COUNT_BITS-1:0] count;
  logic [ADC_BITS-1:0]   hi_code;
  logic [ADC_BITS-1:0]   lo_code;

  // strict band test, low bound signed
  function automatic bit band_hit(input logic [VALUE_BITS-1:0] x,
                                  input logic signed [LOW_BITS-1:0] lo,
                                  input logic [VALUE_BITS-1:0] hi);
    longint xs;
    longint ls;
    xs = x;
    ls = lo;
    return (xs > ls) && (x < hi);
  endfunction

  task automatic note_error(input string what, input longint want, input longint got);
    errors++;
    $display("%0t ns: %s expected %0d, actual %0d", $time, what, want, got);
  endtask

  // fold one sample into the window; a closing sample queues its reading
  task automatic fold_sample(input logic [ADC_BITS-1:0] code);
    longint unsigned window;
    longint unsigned span;
    longint unsigned pk;
    longint unsigned rm;
    logic [ADC_BITS-1:0] diff;
    reading_t r;
    window = (win_len == 0) ? 1 : win_len;
    if (code > hi_code) hi_code = code;
    if (code < lo_code) lo_code = code;
    if (longint'(count) + 1 < window && count != {COUNT_BITS{1'b1}}) begin
      count = count + 1'b1;
      return;
    end
    diff = hi_code - lo_code;
    span = diff;
    pk   = (span * gain) >> Q_SHIFT;
    rm   = (pk * INV_SQRT2_Q16) >> Q_SHIFT;
    if (pk > VALUE_MAX) pk = VALUE_MAX;
    if (rm > VALUE_MAX) rm = VALUE_MAX;
    r.span = diff;
    r.peak = pk[VALUE_BITS-1:0];
    r.rms  = rm[VALUE_BITS-1:0];
    r.hit  = band_hit(r.rms, b1_lo, b1_hi) || band_hit(r.rms, b2_lo, b2_hi);
    readings_due.push_back(r);
    count   = '0;
    hi_code = '0;
    lo_code = '1;
  endtask

  // track registers, samples and result items at each edge
  always @(posedge clk) begin : track
    reading_t want;
    if (rst) begin
      win_len = RST_SAMPLES_PER_WINDOW;
      gain    = RST_PEAK_GAIN;
      b1_lo   = RST_BAND_ONE_LOW;
      b1_hi   = RST_BAND_ONE_HIGH;
      b2_lo   = RST_BAND_TWO_LOW;
      b2_hi   = RST_BAND_TWO_HIGH;
      count   = '0;
      hi_code = '0;
      lo_code = '1;
      readings_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_SAMPLES_PER_WINDOW: win_len = cfg_data[WIN_BITS-1:0];
          CFG_PEAK_GAIN:          gain    = cfg_data[GAIN_BITS-1:0];
          CFG_BAND_ONE_LOW:       b1_lo   = cfg_data[LOW_BITS-1:0];
          CFG_BAND_ONE_HIGH:      b1_hi   = cfg_data[VALUE_BITS-1:0];
          CFG_BAND_TWO_LOW:       b2_lo   = cfg_data[LOW_BITS-1:0];
          CFG_BAND_TWO_HIGH:      b2_hi   = cfg_data[VALUE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        fold_sample(sample_code);
      if (out_valid && !out_stall) begin
        if (readings_due.size() == 0) begin
          note_error("unexpected result item, span_code", -1, span_code);
        end else begin
          want = readings_due.pop_front();
          if (span_code !== want.span) note_error("span_code", want.span, span_code);
          if (peak_value !== want.peak) note_error("peak_value", want.peak, peak_value);
          if (rms_value !== want.rms) note_error("rms_value", want.rms, rms_value);
          if (in_range !== want.hit) note_error("in_range", want.hit, in_range);
        end
      end
    end
    pending_readings <= readings_due.size();
    fail_count       <= errors;
  end

endmodule

### bench/windowed_peak_rms_meter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_peak_rms_meter_unit_tb: bench for the windowed peak/rms meter
// Runs a window at the reset settings, a directed set of windows (window of
// zero, rail-to-rail spans, zero gain, band edges, empty bands), random
// register settings with random sample streams and idling on both sides and
// a long receiver hold-off. Results are checked by the checker module
// instantiated beside the meter.
// ----------------------------------------------------------------------------
module windowed_peak_rms_meter_unit_tb;
  import wpm_pkg::*;

  localparam int ADC_BITS       = 12;
  localparam int COUNT_BITS     = 16;
  localparam int RANDOM_ITEMS   = 840;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  // indexes outside the register map
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_SIX   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_SEVEN = 3'd7;

  typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_RAILS} spread_t;

  typedef struct {
    logic [WIN_BITS-1:0]   win;
    logic [GAIN_BITS-1:0]  gain;
    logic [LOW_BITS-1:0]   lo1;
    logic [VALUE_BITS-1:0] hi1;
    logic [LOW_BITS-1:0]   lo2;
    logic [VALUE_BITS-1:0] hi2;
  } meter_setup_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [ADC_BITS-1:0]   sample_code;
  logic                  out_valid;
  logic                  out_stall;
  logic [ADC_BITS-1:0]   span_code;
  logic [VALUE_BITS-1:0] peak_value;
  logic [VALUE_BITS-1:0] rms_value;
  logic                  in_range;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending_readings;
  int idle_cycles = 0;
  int gap_pct = 10;
  bit no_idle = 1'b0;
  bit hold_request = 1'b0;
  bit hold_active = 1'b0;

  windowed_peak_rms_meter_unit #(
    .ADC_BITS(ADC_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample_code(sample_code),
    .out_valid(out_valid), .out_stall(out_stall), .span_code(span_code),
    .peak_value(peak_value), .rms_value(rms_value), .in_range(in_range),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  wpm_reading_checker #(
    .ADC_BITS(ADC_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) reading_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample_code(sample_code),
    .out_valid(out_valid), .out_stall(out_stall), .span_code(span_code),
    .peak_value(peak_value), .rms_value(rms_value), .in_range(in_range),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_readings(pending_readings)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, free runs and one long hold-off on request
  initial begin : result_sink
    int span_len;
    int r;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active = 1'b0;
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (no_idle) begin
          out_stall <= 1'b0;
          span_len = 1;
        end else if (r < 50) begin
          out_stall <= 1'b0;
          span_len = $urandom_range(1, 10);
        end else if (r < 55) begin
          out_stall <= 1'b0;
          span_len = $urandom_range(50, 200);
        end else if (r < 95) begin
          out_stall <= 1'b1;
          span_len = $urandom_range(1, 4);
        end else begin
          out_stall <= 1'b1;
          span_len = $urandom_range(15, 60);
        end
        repeat (span_len - 1) @(posedge clk);
      end
    end
  end

  // offer one sample, with a random gap first, and wait until it is taken
  task automatic send_sample(input logic [ADC_BITS-1:0] code);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) < gap_pct)
      gap = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 50);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    sample_code <= code;
    do @(posedge clk); while (in_stall);
  endtask

  // wait until every reading due has come out and the meter has settled
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_readings != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; the caller lowers cfg_write after a batch
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // write all registers, junk in the unused upper data bits
  task automatic apply_setup(input meter_setup_t s);
    logic [31:0] junk;
    junk = $urandom;
    put_reg(CFG_SAMPLES_PER_WINDOW, {junk[7:0], s.win});
    put_reg(CFG_PEAK_GAIN, s.gain);
    put_reg(CFG_BAND_ONE_LOW, {junk[10:8], s.lo1});
    put_reg(CFG_BAND_ONE_HIGH, {junk[14:11], s.hi1});
    put_reg(CFG_BAND_TWO_LOW, {junk[17:15], s.lo2});
    put_reg(CFG_BAND_TWO_HIGH, {junk[21:18], s.hi2});
    if (junk[22]) put_reg(CFG_UNMAPPED_SIX, CFG_DATA_W'($urandom));
    if (junk[23]) put_reg(CFG_UNMAPPED_SEVEN, CFG_DATA_W'($urandom));
    cfg_write <= 1'b0;
  endtask

  function automatic logic [ADC_BITS-1:0] pick_code(input spread_t spread, input int center);
    int v;
    int r;
    r = $urandom_range(0, 99);
    case (spread)
      SPREAD_NARROW: begin
        v = center + $urandom_range(0, 40) - 20;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      SPREAD_RAILS: v = (r < 40) ? 0 : (r < 80) ? 4095 : $urandom_range(0, 4095);
      default: v = $urandom_range(0, 4095);
    endcase
    return v[ADC_BITS-1:0];
  endfunction

  // band bound: mostly inside the reachable rms range, sometimes at the rails
  function automatic int pick_bound(input int lim, input bit is_low);
    int r;
    r = $urandom_range(0, 99);
    if (is_low && r < 10) return -1;
    if (r < 15) return 1048575;
    if (r < 20) return 0;
    return $urandom_range(0, lim);
  endfunction

  function automatic meter_setup_t random_setup();
    meter_setup_t s;
    int r;
    int lim;
    int b;
    longint rms_top;
    r = $urandom_range(0, 99);
    if (r < 10) s.win = 0;
    else if (r < 15) s.win = 1;
    else if (r < 85) s.win = WIN_BITS'($urandom_range(2, 12));
    else if (r < 95) s.win = WIN_BITS'($urandom_range(13, 200));
    else s.win = WIN_BITS'($urandom_range(201, 400));
    r = $urandom_range(0, 99);
    if (r < 5) s.gain = 0;
    else if (r < 10) s.gain = '1;
    else if (r < 30) s.gain = 26407;
    else if (r < 50) s.gain = RST_PEAK_GAIN;
    else if (r < 60) s.gain = 65536;
    else s.gain = GAIN_BITS'($urandom);
    rms_top = (((longint'(4095) * s.gain) >> 16) * 46341) >> 16;
    lim = (rms_top + 2 > 1048575) ? 1048575 : int'(rms_top) + 2;
    b = pick_bound(lim, 1'b1);
    s.lo1 = b[LOW_BITS-1:0];
    b = pick_bound(lim, 1'b0);
    s.hi1 = b[VALUE_BITS-1:0];
    b = pick_bound(lim, 1'b1);
    s.lo2 = b[LOW_BITS-1:0];
    b = pick_bound(lim, 1'b0);
    s.hi2 = b[VALUE_BITS-1:0];
    return s;
  endfunction

  initial begin : stimulus
    meter_setup_t s;
    spread_t spread;
    int n;
    int center;
    int random_sent;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    sample_code <= '0;
    cfg_write   <= 1'b0;
    cfg_index   <= CFG_SAMPLES_PER_WINDOW;
    cfg_data    <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // one window at the reset settings
    repeat (1000) send_sample(pick_code(SPREAD_FULL, 0));
    drain();

    // window of zero acts as one; a low bound of -1 lets zero rms match
    put_reg(CFG_UNMAPPED_SIX, 24'hFFFFFF);
    s = '{win: 0, gain: 24'hFFFFFF, lo1: '1, hi1: 1, lo2: 21'h0FFFFF, hi2: 0};
    apply_setup(s);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'h555);
    send_sample(12'hAAA);
    drain();

    // rail-to-rail spans at the largest gain
    put_reg(CFG_UNMAPPED_SEVEN, 24'h000000);
    s = '{win: 2, gain: 24'hFFFFFF, lo1: 0, hi1: 0, lo2: '1, hi2: 20'hFFFFF};
    apply_setup(s);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd4095);
    send_sample(12'd0);
    drain();

    // zero gain, empty band one and a band two above zero
    s = '{win: 2, gain: 0, lo1: '1, hi1: 0, lo2: 0, hi2: 5};
    apply_setup(s);
    send_sample(12'd100);
    send_sample(12'd3000);
    drain();

    // unity gain: rms on and next to the band edges
    s = '{win: 2, gain: 65536, lo1: 69, hi1: 71, lo2: 71, hi2: 72};
    apply_setup(s);
    send_sample(12'd100);
    send_sample(12'd200);
    send_sample(12'd0);
    send_sample(12'd102);
    send_sample(12'd5);
    send_sample(12'd5);
    drain();

    // voltage settings, three-sample window
    s = '{win: 3, gain: RST_PEAK_GAIN, lo1: RST_BAND_ONE_LOW, hi1: RST_BAND_ONE_HIGH,
          lo2: RST_BAND_TWO_LOW, hi2: RST_BAND_TWO_HIGH};
    apply_setup(s);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd2048);
    drain();

    // random settings with random sample streams
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      apply_setup(random_setup());
      no_idle = ($urandom_range(0, 99) < 15);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 50;
      endcase
      spread = spread_t'($urandom_range(0, 2));
      center = $urandom_range(0, 4095);
      n = $urandom_range(10, 80);
      repeat (n) send_sample(pick_code(spread, center));
      random_sent += n;
      drain();
    end
    no_idle = 1'b0;

    // long receiver hold-off while every sample closes a window
    s = '{win: 1, gain: RST_PEAK_GAIN, lo1: RST_BAND_ONE_LOW, hi1: RST_BAND_ONE_HIGH,
          lo2: RST_BAND_TWO_LOW, hi2: RST_BAND_TWO_HIGH};
    apply_setup(s);
    gap_pct = 0;
    hold_request = 1'b1;
    wait (hold_active);
    repeat (40) send_sample(pick_code(SPREAD_FULL, 0));
    drain();

    if (fail_count == 0 && pending_readings == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/wpm_pkg.sv
hw/rtl/wpm_mul.sv
hw/rtl/wpm_ctrl.sv
hw/rtl/windowed_peak_rms_meter_unit.sv
hw/rtl/wpm_checker.sv
bench/wpm_reading_checker.sv
bench/windowed_peak_rms_meter_unit_tb.sv
